// ----- rtl/tcnih_pkg.sv -----
// shared types and constants for the ternary neighbourhood implication block
// no dependencies; used by every module under rtl
`timescale 1ns / 1ps
`default_nettype none

package tcnih_pkg;

	localparam int NUM_CELLS = 9;
	localparam int NUM_LANES = 8;
	localparam int LANE_BITS = 6;
	localparam int LANE_SIZE = 1 << LANE_BITS;
	localparam int HI_BITS   = 3;
	localparam int RULE_W    = 64;
	localparam int IDX_W     = 3;

	localparam logic [1:0] CELL_DEAD    = 2'd0;
	localparam logic [1:0] CELL_ALIVE   = 2'd1;
	localparam logic [1:0] CELL_UNKNOWN = 2'd2;
	localparam logic [1:0] CELL_UNDEF   = 2'd3;

	localparam logic [1:0] NS_DEAD    = 2'd0;
	localparam logic [1:0] NS_ALIVE   = 2'd1;
	localparam logic [1:0] NS_UNKNOWN = 2'd2;

	localparam logic [1:0] FORCE_NONE = 2'd2;

	// decoded neighbourhood for one beat
	typedef struct packed {
		logic [NUM_CELLS-1:0] allow0;
		logic [NUM_CELLS-1:0] allow1;
		logic [NUM_CELLS-1:0] unknown;
		logic                 undef;
		logic                 tgt;
		logic                 tgt_known;
	} cell_ctl_t;

	// what one lane found over its slice of the rule table
	typedef struct packed {
		logic                 seen0;
		logic                 seen1;
		logic [NUM_CELLS-1:0] p0;
		logic [NUM_CELLS-1:0] p1;
	} lane_res_t;

endpackage

`default_nettype wire

// ----- rtl/tcnih_lane.sv -----
// one lane: scans a 64-entry slice of the rule table against the neighbourhood
// depends on tcnih_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcnih_lane #(
	parameter int LANE_IDX = 0
) (
	input  wire                           clk,
	input  tcnih_pkg::cell_ctl_t          ctl_s1,
	input  wire [tcnih_pkg::RULE_W-1:0]   rule_word,
	output tcnih_pkg::lane_res_t          res_s2
);

	tcnih_pkg::lane_res_t res_d;

	always_comb begin
		logic [tcnih_pkg::NUM_CELLS-1:0] idx;
		logic [tcnih_pkg::LANE_BITS-1:0] bi;
		logic                            m;
		logic                            h;
		res_d = '0;
		for (int b = 0; b < tcnih_pkg::LANE_SIZE; b++) begin
			bi  = tcnih_pkg::LANE_BITS'(b);
			idx = {tcnih_pkg::HI_BITS'(LANE_IDX), bi};
			m   = 1'b1;
			for (int k = 0; k < tcnih_pkg::NUM_CELLS; k++) begin
				m = m & (idx[k] ? ctl_s1.allow1[k] : ctl_s1.allow0[k]);
			end
			h = m & (rule_word[bi] == ctl_s1.tgt);
			res_d.seen1 = res_d.seen1 | (m & rule_word[bi]);
			res_d.seen0 = res_d.seen0 | (m & ~rule_word[bi]);
			for (int k = 0; k < tcnih_pkg::NUM_CELLS; k++) begin
				if (idx[k]) begin
					res_d.p1[k] = res_d.p1[k] | h;
				end else begin
					res_d.p0[k] = res_d.p0[k] | h;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		res_s2 <= res_d;
	end

endmodule

`default_nettype wire

// ----- rtl/tcnih_merge.sv -----
// merging stage: combines lane results into the forward value, the contradiction flag and forced cells
// depends on tcnih_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcnih_merge (
	input  wire                                                  clk,
	input  wire                                                  arst_n,
	input  wire                                                  valid_s2,
	input  tcnih_pkg::cell_ctl_t                                 ctl_s2,
	input  tcnih_pkg::lane_res_t [tcnih_pkg::NUM_LANES-1:0]      lane_res,
	output logic                                                 done_q,
	output logic [1:0]                                           next_state_q,
	output logic                                                 contra_q,
	output logic [tcnih_pkg::NUM_CELLS-1:0][1:0]                 force_q
);

	logic                                  seen0;
	logic                                  seen1;
	logic [tcnih_pkg::NUM_CELLS-1:0]       p0;
	logic [tcnih_pkg::NUM_CELLS-1:0]       p1;
	logic [1:0]                            ns_d;
	logic                                  contra_d;
	logic [tcnih_pkg::NUM_CELLS-1:0][1:0]  force_d;

	always_comb begin
		seen0 = 1'b0;
		seen1 = 1'b0;
		p0    = '0;
		p1    = '0;
		for (int w = 0; w < tcnih_pkg::NUM_LANES; w++) begin
			seen0 = seen0 | lane_res[w].seen0;
			seen1 = seen1 | lane_res[w].seen1;
			p0    = p0 | lane_res[w].p0;
			p1    = p1 | lane_res[w].p1;
		end

		if (ctl_s2.undef || (seen0 && seen1)) begin
			ns_d = tcnih_pkg::NS_UNKNOWN;
		end else if (seen1) begin
			ns_d = tcnih_pkg::NS_ALIVE;
		end else begin
			ns_d = tcnih_pkg::NS_DEAD;
		end

		// no completion reaches the target
		contra_d = !ctl_s2.undef && ctl_s2.tgt_known &&
			!(ctl_s2.tgt ? seen1 : seen0);

		for (int k = 0; k < tcnih_pkg::NUM_CELLS; k++) begin
			if (!ctl_s2.undef && !contra_d && ctl_s2.tgt_known &&
				ctl_s2.unknown[k] && (p0[k] != p1[k])) begin
				force_d[k] = {1'b0, p1[k]};
			end else begin
				force_d[k] = tcnih_pkg::FORCE_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		next_state_q <= ns_d;
		contra_q     <= contra_d;
		force_q      <= force_d;
	end

endmodule

`default_nettype wire

// ----- rtl/ternary_ca_neighbourhood_implication.sv -----
// top level of the ternary neighbourhood implication block
// depends on tcnih_pkg, tcnih_lane, tcnih_merge
//
// usage: raise start with the nine cells and next_center; the beat is taken
// when start is high and busy is low. busy is high only while in reset and
// the cycle after, so a new beat can be taken every cycle.
// the result (next_state, contradiction, force_*) is driven with done high for
// exactly one cycle, after passing the input register, the lane result
// registers and the merge output register; results come out in order, one per
// beat, and the receiver cannot stall them.
// pipeline: input register, eight lanes each scanning 64 rule entries,
// then a merging stage that ORs the lanes and forms the outputs.
// throughput is one beat per cycle.
// rule table: cfg_we writes cfg_data into rule word cfg_index; write only
// while no beat is in flight. reset clears the rule table and the valid flags.
`timescale 1ns / 1ps
`default_nettype none

module ternary_ca_neighbourhood_implication (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	output logic                               busy,
	input  wire  [1:0]                         cell_nw,
	input  wire  [1:0]                         cell_n,
	input  wire  [1:0]                         cell_ne,
	input  wire  [1:0]                         cell_w,
	input  wire  [1:0]                         cell_c,
	input  wire  [1:0]                         cell_e,
	input  wire  [1:0]                         cell_sw,
	input  wire  [1:0]                         cell_s,
	input  wire  [1:0]                         cell_se,
	input  wire  [1:0]                         next_center,
	input  wire                                cfg_we,
	input  wire  [tcnih_pkg::IDX_W-1:0]        cfg_index,
	input  wire  [tcnih_pkg::RULE_W-1:0]       cfg_data,
	output logic                               done,
	output logic [1:0]                         next_state,
	output logic                               contradiction,
	output logic [1:0]                         force_nw,
	output logic [1:0]                         force_n,
	output logic [1:0]                         force_ne,
	output logic [1:0]                         force_w,
	output logic [1:0]                         force_c,
	output logic [1:0]                         force_e,
	output logic [1:0]                         force_sw,
	output logic [1:0]                         force_s,
	output logic [1:0]                         force_se
);

	logic                                       busy_q;
	logic                                       accept;
	logic [tcnih_pkg::NUM_CELLS-1:0][1:0]       cells;
	tcnih_pkg::cell_ctl_t                       ctl_d;
	tcnih_pkg::cell_ctl_t                       ctl_s1;
	tcnih_pkg::cell_ctl_t                       ctl_s2;
	logic                                       valid_s1;
	logic                                       valid_s2;
	logic [tcnih_pkg::RULE_W-1:0]               rule_q [tcnih_pkg::NUM_LANES];
	tcnih_pkg::lane_res_t [tcnih_pkg::NUM_LANES-1:0] lane_res;
	logic [1:0]                                 ns_q;
	logic                                       contra_q;
	logic [tcnih_pkg::NUM_CELLS-1:0][1:0]       force_q;
	logic                                       done_q;

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	assign cells = {cell_se, cell_s, cell_sw, cell_e, cell_c, cell_w,
		cell_ne, cell_n, cell_nw};

	always_comb begin
		ctl_d = '0;
		for (int k = 0; k < tcnih_pkg::NUM_CELLS; k++) begin
			ctl_d.allow0[k]  = (cells[k] == tcnih_pkg::CELL_DEAD) ||
				(cells[k] == tcnih_pkg::CELL_UNKNOWN);
			ctl_d.allow1[k]  = (cells[k] == tcnih_pkg::CELL_ALIVE) ||
				(cells[k] == tcnih_pkg::CELL_UNKNOWN);
			ctl_d.unknown[k] = (cells[k] == tcnih_pkg::CELL_UNKNOWN);
			ctl_d.undef      = ctl_d.undef | (cells[k] == tcnih_pkg::CELL_UNDEF);
		end
		ctl_d.tgt       = next_center[0];
		ctl_d.tgt_known = !next_center[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			busy_q   <= 1'b0;
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_d;
		end
		ctl_s2 <= ctl_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < tcnih_pkg::NUM_LANES; w++) begin
				rule_q[w] <= '0;
			end
		end else if (cfg_we) begin
			rule_q[cfg_index] <= cfg_data;
		end
	end

	for (genvar w = 0; w < tcnih_pkg::NUM_LANES; w++) begin : g_lane
		tcnih_lane #(
			.LANE_IDX (w)
		) u_lane (
			.clk       (clk),
			.ctl_s1    (ctl_s1),
			.rule_word (rule_q[w]),
			.res_s2    (lane_res[w])
		);
	end

	tcnih_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s2     (valid_s2),
		.ctl_s2       (ctl_s2),
		.lane_res     (lane_res),
		.done_q       (done_q),
		.next_state_q (ns_q),
		.contra_q     (contra_q),
		.force_q      (force_q)
	);

	assign done          = done_q;
	assign next_state    = ns_q;
	assign contradiction = contra_q;
	assign force_nw      = force_q[0];
	assign force_n       = force_q[1];
	assign force_ne      = force_q[2];
	assign force_w       = force_q[3];
	assign force_c       = force_q[4];
	assign force_e       = force_q[5];
	assign force_sw      = force_q[6];
	assign force_s       = force_q[7];
	assign force_se      = force_q[8];

	// one result beat for every accepted beat
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(accept, 3))
		else $error("done does not follow accepted beat");

	a_contra_known: assert property (@(posedge clk) disable iff (!arst_n)
		done && contradiction |-> next_state != tcnih_pkg::NS_UNKNOWN)
		else $error("contradiction with unknown forward value");

	a_contra_no_force: assert property (@(posedge clk) disable iff (!arst_n)
		done && contradiction |-> force_nw == tcnih_pkg::FORCE_NONE &&
			force_c == tcnih_pkg::FORCE_NONE && force_se == tcnih_pkg::FORCE_NONE)
		else $error("forced cell while contradiction flagged");

	// a known forward value reaches the target for every completion
	a_force_needs_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		done && (force_nw != tcnih_pkg::FORCE_NONE || force_c != tcnih_pkg::FORCE_NONE ||
			force_se != tcnih_pkg::FORCE_NONE) |-> next_state == tcnih_pkg::NS_UNKNOWN)
		else $error("forced cell with known forward value");

endmodule

`default_nettype wire

// ----- tb/sv/ternary_ca_neighbourhood_implication_tb.sv -----
// testbench for the ternary neighbourhood implication block: directed and random beats
// over several rule tables, each result checked against an in-bench implication predictor
// depends on tcnih_pkg and ternary_ca_neighbourhood_implication
`timescale 1ns / 1ps

module ternary_ca_neighbourhood_implication_tb;
	import tcnih_pkg::*;

	localparam int POS_NW = 0;
	localparam int POS_N  = 1;
	localparam int POS_NE = 2;
	localparam int POS_W  = 3;
	localparam int POS_C  = 4;
	localparam int POS_E  = 5;
	localparam int POS_SW = 6;
	localparam int POS_S  = 7;
	localparam int POS_SE = 8;
	localparam int TABLE_BITS = NUM_LANES * RULE_W;
	localparam int PHASES = 9;
	localparam int BEATS_PER_PHASE = 190;

	typedef struct packed {
		logic [NUM_CELLS-1:0][1:0] cells;
		logic [1:0]                target;
	} nbhd_t;

	typedef struct packed {
		logic [1:0]                ns;
		logic                      contra;
		logic [NUM_CELLS-1:0][1:0] frc;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] cell_nw = 2'd0, cell_n = 2'd0, cell_ne = 2'd0;
	logic [1:0] cell_w = 2'd0, cell_c = 2'd0, cell_e = 2'd0;
	logic [1:0] cell_sw = 2'd0, cell_s = 2'd0, cell_se = 2'd0;
	logic [1:0] next_center = 2'd0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [RULE_W-1:0] cfg_data = '0;
	logic done;
	logic [1:0] next_state;
	logic contradiction;
	logic [1:0] force_nw, force_n, force_ne, force_w, force_c, force_e;
	logic [1:0] force_sw, force_s, force_se;

	logic [TABLE_BITS-1:0] rule_table = '0;
	nbhd_t neighbourhoods_to_send [$];
	verdict_t expected_verdicts [$];
	nbhd_t on_wire = '0;
	int gap_left = 0;
	bit gaps_on = 1'b1;
	int n_errors = 0;
	int n_checked = 0;
	int n_contra_seen = 0;
	int n_forced_seen = 0;

	ternary_ca_neighbourhood_implication uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cell_nw(cell_nw), .cell_n(cell_n), .cell_ne(cell_ne),
		.cell_w(cell_w), .cell_c(cell_c), .cell_e(cell_e),
		.cell_sw(cell_sw), .cell_s(cell_s), .cell_se(cell_se),
		.next_center(next_center),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .next_state(next_state), .contradiction(contradiction),
		.force_nw(force_nw), .force_n(force_n), .force_ne(force_ne),
		.force_w(force_w), .force_c(force_c), .force_e(force_e),
		.force_sw(force_sw), .force_s(force_s), .force_se(force_se)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// agreement of the rule table over every completion of the open cells
	function automatic logic [1:0] table_agreement(logic [8:0] alive_bits, logic [8:0] open_bits);
		logic [8:0] sub;
		bit seen0, seen1;
		sub = '0;
		seen0 = 1'b0;
		seen1 = 1'b0;
		do begin
			if (rule_table[alive_bits | sub])
				seen1 = 1'b1;
			else
				seen0 = 1'b1;
			sub = (sub - open_bits) & open_bits;
		end while (sub != 0);
		if (seen0 && seen1)
			return NS_UNKNOWN;
		return seen1 ? NS_ALIVE : NS_DEAD;
	endfunction

	function automatic verdict_t imply_neighbourhood(nbhd_t nb);
		verdict_t v;
		logic [8:0] alive_bits, open_bits, pick;
		logic [1:0] f0, f1;
		bit undef, target_known, p0, p1;
		alive_bits = '0;
		open_bits = '0;
		undef = 1'b0;
		for (int k = 0; k < NUM_CELLS; k++) begin
			case (nb.cells[k])
				CELL_UNDEF:   undef = 1'b1;
				CELL_UNKNOWN: open_bits[k] = 1'b1;
				CELL_ALIVE:   alive_bits[k] = 1'b1;
				default: ;
			endcase
		end
		target_known = (nb.target == CELL_DEAD) || (nb.target == CELL_ALIVE);
		v.ns = undef ? NS_UNKNOWN : table_agreement(alive_bits, open_bits);
		v.contra = (v.ns != NS_UNKNOWN) && target_known && (v.ns != nb.target);
		for (int k = 0; k < NUM_CELLS; k++)
			v.frc[k] = FORCE_NONE;
		if (!undef && !v.contra && target_known) begin
			for (int k = 0; k < NUM_CELLS; k++) begin
				if (open_bits[k]) begin
					pick = 9'd1 << k;
					f0 = table_agreement(alive_bits, open_bits & ~pick);
					f1 = table_agreement(alive_bits | pick, open_bits & ~pick);
					p0 = (f0 == NS_UNKNOWN) || (f0 == nb.target);
					p1 = (f1 == NS_UNKNOWN) || (f1 == nb.target);
					if (p0 != p1)
						v.frc[k] = p1 ? NS_ALIVE : NS_DEAD;
				end
			end
		end
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic nbhd_t uniform_nbhd(logic [1:0] fill, logic [1:0] tgt);
		nbhd_t nb;
		for (int k = 0; k < NUM_CELLS; k++)
			nb.cells[k] = fill;
		nb.target = tgt;
		return nb;
	endfunction

	// mostly two-valued cells with a few open ones; some with undefined cells, some fully random
	function automatic nbhd_t random_nbhd();
		nbhd_t nb;
		int r, pos, n_open, n_undef;
		r = $urandom_range(0, 99);
		for (int k = 0; k < NUM_CELLS; k++)
			nb.cells[k] = (r < 85) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(0, 3));
		if (r < 85) begin
			n_open = $urandom_range(0, 9);
			repeat (n_open) begin
				pos = $urandom_range(0, NUM_CELLS - 1);
				nb.cells[pos] = CELL_UNKNOWN;
			end
		end
		if (r >= 70 && r < 85) begin
			n_undef = $urandom_range(1, 2);
			repeat (n_undef) begin
				pos = $urandom_range(0, NUM_CELLS - 1);
				nb.cells[pos] = CELL_UNDEF;
			end
		end
		nb.target = ($urandom_range(0, 9) < 7) ? 2'($urandom_range(0, 1)) :
			2'($urandom_range(2, 3));
		return nb;
	endfunction

	// birth on three, survival on two or three
	function automatic logic [TABLE_BITS-1:0] life_rules();
		logic [TABLE_BITS-1:0] tbl;
		logic [8:0] ix;
		int cnt;
		for (int i = 0; i < TABLE_BITS; i++) begin
			ix = i[8:0];
			cnt = 0;
			for (int k = 0; k < NUM_CELLS; k++)
				if (k != POS_C && ix[k])
					cnt++;
			tbl[i] = (cnt == 3) || (ix[POS_C] && cnt == 2);
		end
		return tbl;
	endfunction

	function automatic logic [TABLE_BITS-1:0] random_rules();
		logic [TABLE_BITS-1:0] tbl;
		for (int w = 0; w < NUM_LANES; w++)
			tbl[w*RULE_W +: RULE_W] = {$urandom, $urandom};
		return tbl;
	endfunction

	task automatic load_rules(input logic [TABLE_BITS-1:0] tbl);
		for (int w = 0; w < NUM_LANES; w++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= w[IDX_W-1:0];
			cfg_data <= tbl[w*RULE_W +: RULE_W];
			rule_table[w*RULE_W +: RULE_W] = tbl[w*RULE_W +: RULE_W];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		while (neighbourhoods_to_send.size() != 0 || start || expected_verdicts.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin : drive
		nbhd_t nb;
		if (arst_n) begin
			if (start && !busy)
				expected_verdicts.push_back(imply_neighbourhood(on_wire));
			if (start && busy) begin
				// beat held until taken
			end else if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (neighbourhoods_to_send.size() != 0) begin
				nb = neighbourhoods_to_send.pop_front();
				on_wire <= nb;
				cell_nw <= nb.cells[POS_NW];
				cell_n <= nb.cells[POS_N];
				cell_ne <= nb.cells[POS_NE];
				cell_w <= nb.cells[POS_W];
				cell_c <= nb.cells[POS_C];
				cell_e <= nb.cells[POS_E];
				cell_sw <= nb.cells[POS_SW];
				cell_s <= nb.cells[POS_S];
				cell_se <= nb.cells[POS_SE];
				next_center <= nb.target;
				start <= 1'b1;
				gap_left <= pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : observe
		verdict_t got, want;
		bit bad;
		if (arst_n && done) begin
			got.ns = next_state;
			got.contra = contradiction;
			got.frc = {force_se, force_s, force_sw, force_e, force_c, force_w,
				force_ne, force_n, force_nw};
			if (expected_verdicts.size() == 0) begin
				n_errors++;
				$display("%0t: result beat with nothing expected", $time);
			end else begin
				want = expected_verdicts.pop_front();
				n_checked++;
				bad = (got.ns !== want.ns) || (got.contra !== want.contra);
				for (int k = 0; k < NUM_CELLS; k++)
					if (got.frc[k] !== want.frc[k])
						bad = 1'b1;
				if (want.contra)
					n_contra_seen++;
				if (want.frc != {NUM_CELLS{FORCE_NONE}})
					n_forced_seen++;
				if (bad) begin
					n_errors++;
					$display("%0t: expected ns %0d contra %0d force %h, got ns %0d contra %0d force %h",
						$time, want.ns, want.contra, want.frc, got.ns, got.contra, got.frc);
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("ternary_ca_neighbourhood_implication_tb: errors");
		$finish;
	end

	initial begin : stimulus
		nbhd_t nb;
		logic [TABLE_BITS-1:0] tbl;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset table is all dead
		neighbourhoods_to_send.push_back(uniform_nbhd(CELL_DEAD, CELL_DEAD));
		neighbourhoods_to_send.push_back(uniform_nbhd(CELL_UNKNOWN, CELL_ALIVE));
		neighbourhoods_to_send.push_back(uniform_nbhd(CELL_UNKNOWN, CELL_UNKNOWN));
		settle();

		load_rules(life_rules());
		neighbourhoods_to_send.push_back(uniform_nbhd(CELL_DEAD, CELL_DEAD));
		neighbourhoods_to_send.push_back(uniform_nbhd(CELL_ALIVE, CELL_ALIVE));
		neighbourhoods_to_send.push_back(uniform_nbhd(CELL_UNDEF, CELL_UNDEF));
		neighbourhoods_to_send.push_back(uniform_nbhd(CELL_UNKNOWN, CELL_DEAD));
		neighbourhoods_to_send.push_back(uniform_nbhd(CELL_UNKNOWN, CELL_ALIVE));
		neighbourhoods_to_send.push_back(uniform_nbhd(CELL_UNKNOWN, CELL_UNKNOWN));
		neighbourhoods_to_send.push_back(uniform_nbhd(CELL_UNKNOWN, CELL_UNDEF));
		// three live neighbours: birth or survival either way
		nb = uniform_nbhd(CELL_DEAD, CELL_ALIVE);
		nb.cells[POS_NW] = CELL_ALIVE;
		nb.cells[POS_N] = CELL_ALIVE;
		nb.cells[POS_NE] = CELL_ALIVE;
		nb.cells[POS_C] = CELL_UNKNOWN;
		neighbourhoods_to_send.push_back(nb);
		nb.target = CELL_DEAD;
		neighbourhoods_to_send.push_back(nb);
		// two live neighbours: the centre is forced by the target
		nb.cells[POS_NE] = CELL_DEAD;
		neighbourhoods_to_send.push_back(nb);
		nb.target = CELL_ALIVE;
		neighbourhoods_to_send.push_back(nb);
		// dead centre: the open neighbour must be alive for a birth
		nb.cells[POS_C] = CELL_DEAD;
		nb.cells[POS_NE] = CELL_UNKNOWN;
		neighbourhoods_to_send.push_back(nb);
		nb.target = CELL_UNKNOWN;
		neighbourhoods_to_send.push_back(nb);
		nb.target = CELL_ALIVE;
		nb.cells[POS_SE] = CELL_UNDEF;
		neighbourhoods_to_send.push_back(nb);
		nb.cells[POS_SE] = CELL_UNKNOWN;
		nb.cells[POS_SW] = CELL_UNKNOWN;
		neighbourhoods_to_send.push_back(nb);
		settle();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: tbl = life_rules();
				1: tbl = {TABLE_BITS{1'b1}};
				2: tbl = '0;
				3: tbl = random_rules();
				4: tbl = random_rules() & random_rules() & random_rules();
				5: for (int i = 0; i < TABLE_BITS; i++) tbl[i] = ^i[8:0];
				6: for (int w = 0; w < NUM_LANES; w++)
					tbl[w*RULE_W +: RULE_W] = w[0] ? 64'h5555_5555_5555_5555 :
						64'hAAAA_AAAA_AAAA_AAAA;
				7: tbl = random_rules() | random_rules();
				default: tbl = life_rules();
			endcase
			gaps_on = (phase % 3 != 1);
			load_rules(tbl);
			repeat (BEATS_PER_PHASE)
				neighbourhoods_to_send.push_back(random_nbhd());
			settle();
		end

		repeat (8) @(posedge clk);
		$display("checked %0d beats over %0d rule tables plus reset and directed cases",
			n_checked, PHASES);
		$display("%0d beats with a contradiction, %0d with at least one forced cell",
			n_contra_seen, n_forced_seen);
		if (n_errors == 0 && expected_verdicts.size() == 0)
			$display("ternary_ca_neighbourhood_implication_tb: clean");
		else
			$display("ternary_ca_neighbourhood_implication_tb: errors");
		$finish;
	end

endmodule
